// ===== design/tce_pkg.sv =====
// ---------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the cursor escape encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

   localparam logic [4:0] SCREEN_ROWS    = 5'd24;
   localparam logic [6:0] SCREEN_COLUMNS = 7'd80;
   localparam logic [6:0] MAX_SPACES     = 7'd64;
   localparam logic [7:0] COLUMN_LIMIT   = 8'd255;

   localparam logic [2:0] MODE_CHAR   = 3'd0;
   localparam logic [2:0] MODE_SPACES = 3'd1;
   localparam logic [2:0] MODE_MOVE   = 3'd2;
   localparam logic [2:0] MODE_ERASE  = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_F     = 8'h46;
   localparam logic [7:0] BYTE_H     = 8'h48;
   localparam logic [7:0] BYTE_J     = 8'h4A;
   localparam logic [7:0] BYTE_K     = 8'h4B;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] char_byte;
      logic [6:0] space_count;
      logic [4:0] target_row;
      logic [6:0] target_column;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic step;
   } tce_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
      logic out_free;
   } tce_status_type;

   typedef enum logic [0:0] {
      CTL_IDLE,
      CTL_EMIT
   } ctl_state_type;

endpackage

`default_nettype wire

// ===== design/tce_ctrl.sv =====
// ---------------------------------------------------------------------------
// tce_ctrl
// Controller: takes one command, then steps out its bytes one per beat while the output is free.
// ---------------------------------------------------------------------------
`default_nettype none

module tce_ctrl
   import tce_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire tce_status_type status,
   output tce_cmd_type         cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTL_EMIT;
            end
         end
         CTL_EMIT: begin
            if (status.empty) begin
               state_in = CTL_IDLE;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.last) begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/tce_dp.sv =====
// ---------------------------------------------------------------------------
// tce_dp
// Datapath: cursor state, byte plan for one command, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tce_dp
   import tce_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   input  wire tce_cmd_type     cmd,
   output tce_status_type       status,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data
);

   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [3:0] tens;
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, v} >= 8'(10 * k)) begin
            tens = tens + 4'd1;
         end
      end
      return {1'b0, v} + 8'(tens * 6);
   endfunction

   logic [4:0]      row_ff;
   logic [4:0]      row_in;
   logic [7:0]      col_ff;
   logic [7:0]      col_in;
   logic [3:0][7:0] slot_ff;
   logic [3:0][7:0] slot_in;
   logic [6:0]      remain_ff;
   logic [6:0]      remain_in;
   logic [1:0]      idx_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic [4:0] tgt_row;
   logic [6:0] tgt_col;
   logic [6:0] run_len;
   logic [8:0] col_sum;

   always_comb begin
      tgt_row = req_data.target_row;
      if (req_data.target_row == 5'd0) begin
         tgt_row = 5'd1;
      end else if (req_data.target_row > SCREEN_ROWS) begin
         tgt_row = SCREEN_ROWS;
      end
      tgt_col = req_data.target_column;
      if (req_data.target_column == 7'd0) begin
         tgt_col = 7'd1;
      end else if (req_data.target_column > SCREEN_COLUMNS) begin
         tgt_col = SCREEN_COLUMNS;
      end
      run_len = (req_data.space_count > MAX_SPACES) ? MAX_SPACES : req_data.space_count;
   end

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      slot_in   = '0;
      remain_in = 7'd0;
      col_sum   = 9'd0;
      case (req_data.mode)
         MODE_CHAR: begin
            remain_in  = 7'd1;
            slot_in[0] = req_data.char_byte;
            col_sum    = {1'b0, col_ff} + 9'd1;
            col_in     = (col_sum > {1'b0, COLUMN_LIMIT}) ? COLUMN_LIMIT : col_sum[7:0];
         end
         MODE_SPACES: begin
            remain_in = run_len;
            slot_in   = {4{BYTE_SPACE}};
            col_sum   = {1'b0, col_ff} + {2'b00, run_len};
            col_in    = (col_sum > {1'b0, COLUMN_LIMIT}) ? COLUMN_LIMIT : col_sum[7:0];
         end
         MODE_MOVE: begin
            if (!(row_ff == tgt_row && col_ff == {1'b0, tgt_col})) begin
               row_in = tgt_row;
               col_in = {1'b0, tgt_col};
               if (row_ff == tgt_row && col_ff == ({1'b0, tgt_col} + 8'd1)) begin
                  remain_in  = 7'd1;
                  slot_in[0] = BYTE_BS;
               end else if (({1'b0, row_ff} + 6'd1) == {1'b0, tgt_row} &&
                            (tgt_col == 7'd1 || {1'b0, tgt_col} == col_ff)) begin
                  if ({1'b0, tgt_col} != col_ff) begin
                     remain_in  = 7'd2;
                     slot_in[0] = BYTE_CR;
                     slot_in[1] = BYTE_LF;
                  end else begin
                     remain_in  = 7'd1;
                     slot_in[0] = BYTE_LF;
                  end
               end else if (tgt_row == 5'd1 && tgt_col == 7'd1) begin
                  remain_in  = 7'd2;
                  slot_in[0] = BYTE_ESC;
                  slot_in[1] = BYTE_H;
               end else begin
                  remain_in  = 7'd4;
                  slot_in[0] = BYTE_ESC;
                  slot_in[1] = BYTE_F;
                  slot_in[2] = to_bcd({2'b00, tgt_row - 5'd1});
                  slot_in[3] = to_bcd(tgt_col - 7'd1);
               end
            end
         end
         MODE_ERASE: begin
            remain_in  = 7'd2;
            slot_in[0] = BYTE_ESC;
            slot_in[1] = BYTE_K;
         end
         MODE_CLEAR: begin
            remain_in  = 7'd4;
            slot_in[0] = BYTE_ESC;
            slot_in[1] = BYTE_H;
            slot_in[2] = BYTE_ESC;
            slot_in[3] = BYTE_J;
            row_in     = 5'd1;
            col_in     = 8'd1;
         end
         default: begin
            remain_in = 7'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 5'd1;
         col_ff       <= 8'd1;
         remain_ff    <= 7'd0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            row_ff    <= row_in;
            col_ff    <= col_in;
            slot_ff   <= slot_in;
            remain_ff <= remain_in;
            idx_ff    <= 2'd0;
         end else if (cmd.step) begin
            remain_ff <= remain_ff - 7'd1;
            idx_ff    <= idx_ff + 2'd1;
         end
         if (cmd.step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_data_ff.out_byte  <= slot_ff[idx_ff];
         rsp_data_ff.last_byte <= (remain_ff == 7'd1);
      end
   end

   assign status.empty    = (remain_ff == 7'd0);
   assign status.last     = (remain_ff == 7'd1);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/terminal_cursor_escape_encoder_core.sv =====
// ---------------------------------------------------------------------------
// terminal_cursor_escape_encoder_core
// Screen commands in, terminal bytes out; tracks the cursor position.
// ---------------------------------------------------------------------------
//   channel | ports              | direction | beat
//   req     | req_valid/req_stall | in        | one screen command
//   rsp     | rsp_valid/rsp_stall | out       | one terminal byte
//
// A command is taken while the controller is idle, then its bytes leave one
// per cycle from the byte sequencer while rsp does not stall; no new command is taken until then.
// A stall on rsp holds the output register and the sequencer.
// Reset puts the cursor at row 1, column 1 and sends no bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module terminal_cursor_escape_encoder_core
   import tce_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data
);

   tce_cmd_type    cmd;
   tce_status_type status;

   tce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tce_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command taken but controller not busy");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.last) |=> !req_stall)
      else $error("controller busy after final byte");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_valid)
      else $error("byte stepped but output register empty");

   a_no_step_while_blocked: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!status.empty && status.out_free))
      else $error("byte stepped with nothing to send or output blocked");

endmodule

`default_nettype wire

// ===== tb/tb_terminal_cursor_escape_encoder_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_terminal_cursor_escape_encoder_core
// Sends screen commands to the cursor escape encoder and checks every
// terminal byte that comes back. A cursor-tracking predictor builds the
// expected bytes. The run starts with a table of directed commands and then
// sends random commands that favor cheap cursor moves. The rsp channel stalls
// at random, and commands arrive with random gaps.
// ---------------------------------------------------------------------------

module tb_terminal_cursor_escape_encoder_core;
   import tce_pkg::*;

   localparam int unsigned RANDOM_COMMANDS = 75;
   localparam int unsigned QUIET_COMMANDS  = 20;
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned DRAIN_LIMIT     = 4000;
   localparam int unsigned REPORT_LIMIT    = 10;

   typedef enum int unsigned {
      MOVE_STAY,
      MOVE_BACK,
      MOVE_NEWLINE,
      MOVE_DOWN,
      MOVE_HOME,
      MOVE_NEAR,
      MOVE_ANY
   } move_kind_type;

   typedef struct {
      req_payload_type cmd;
      bit              typed;
      int unsigned     count;
      logic [0:3][7:0] seq;
   } directed_row_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   logic [4:0]       cursor_row    = 5'd1;
   logic [7:0]       cursor_column = 8'd1;
   logic [7:0]       cmd_bytes[$];
   rsp_payload_type  expected_bytes[$];
   directed_row_type directed_rows[$];
   int unsigned      error_count = 0;
   bit               quiet = 1'b0;

   terminal_cursor_escape_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("terminal_cursor_escape_encoder_core test failed");
      $finish;
   end

   function automatic req_payload_type screen_cmd(input logic [2:0] mode,
                                                  input logic [7:0] ch,
                                                  input logic [6:0] n,
                                                  input logic [4:0] row,
                                                  input logic [6:0] col);
      req_payload_type c;
      c.mode          = mode;
      c.char_byte     = ch;
      c.space_count   = n;
      c.target_row    = row;
      c.target_column = col;
      return c;
   endfunction

   function automatic void add_row(input req_payload_type cmd, input bit typed = 1'b0,
                                   input int unsigned count = 0,
                                   input logic [0:3][7:0] seq = '0);
      directed_row_type r;
      r.cmd   = cmd;
      r.typed = typed;
      r.count = count;
      r.seq   = seq;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return 8'(v + (v / 10) * 6);
   endfunction

   function automatic void advance_cursor(input int unsigned n);
      int unsigned c;
      c = cursor_column + n;
      cursor_column = (c > COLUMN_LIMIT) ? COLUMN_LIMIT : 8'(c);
   endfunction

   function automatic void encode_move(input logic [4:0] row_in, input logic [6:0] col_in);
      int unsigned row;
      int unsigned col;
      row = row_in;
      col = col_in;
      if (row < 1) row = 1;
      if (row > SCREEN_ROWS) row = SCREEN_ROWS;
      if (col < 1) col = 1;
      if (col > SCREEN_COLUMNS) col = SCREEN_COLUMNS;
      if (cursor_row == row && cursor_column == col) return;
      if (cursor_row == row && cursor_column == col + 1) begin
         cmd_bytes.push_back(BYTE_BS);
      end else if (cursor_row + 1 == row && (col == 1 || col == cursor_column)) begin
         if (col != cursor_column) cmd_bytes.push_back(BYTE_CR);
         cmd_bytes.push_back(BYTE_LF);
      end else if (row == 1 && col == 1) begin
         cmd_bytes.push_back(BYTE_ESC);
         cmd_bytes.push_back(BYTE_H);
      end else begin
         cmd_bytes.push_back(BYTE_ESC);
         cmd_bytes.push_back(BYTE_F);
         cmd_bytes.push_back(to_bcd(row - 1));
         cmd_bytes.push_back(to_bcd(col - 1));
      end
      cursor_row    = 5'(row);
      cursor_column = 8'(col);
   endfunction

   function automatic void encode_command(input req_payload_type cmd);
      int unsigned n;
      cmd_bytes.delete();
      case (cmd.mode)
         MODE_CHAR: begin
            cmd_bytes.push_back(cmd.char_byte);
            advance_cursor(1);
         end
         MODE_SPACES: begin
            n = (cmd.space_count > MAX_SPACES) ? MAX_SPACES : cmd.space_count;
            repeat (n) cmd_bytes.push_back(BYTE_SPACE);
            advance_cursor(n);
         end
         MODE_MOVE: begin
            encode_move(cmd.target_row, cmd.target_column);
         end
         MODE_ERASE: begin
            cmd_bytes.push_back(BYTE_ESC);
            cmd_bytes.push_back(BYTE_K);
         end
         MODE_CLEAR: begin
            cmd_bytes.push_back(BYTE_ESC);
            cmd_bytes.push_back(BYTE_H);
            cmd_bytes.push_back(BYTE_ESC);
            cmd_bytes.push_back(BYTE_J);
            cursor_row    = 5'd1;
            cursor_column = 8'd1;
         end
         default: ;
      endcase
   endfunction

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
   endfunction

   // Hold the beat until taken, then queue the bytes it must produce.
   task automatic send_command(input req_payload_type cmd, input bit typed,
                               input int unsigned count, input logic [0:3][7:0] seq);
      rsp_payload_type beat;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_command(cmd);
      if (typed) begin
         cmd_bytes.delete();
         for (int i = 0; i < count; i++) cmd_bytes.push_back(seq[i]);
      end
      foreach (cmd_bytes[i]) begin
         beat.out_byte  = cmd_bytes[i];
         beat.last_byte = (i == cmd_bytes.size() - 1);
         expected_bytes.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            note_failure($sformatf("unexpected byte %h last %b",
                                   rsp_data.out_byte, rsp_data.last_byte));
         end else begin
            if (rsp_data.out_byte !== expected_bytes[0].out_byte ||
                rsp_data.last_byte !== expected_bytes[0].last_byte) begin
               note_failure($sformatf("byte %h last %b, expected byte %h last %b",
                                      rsp_data.out_byte, rsp_data.last_byte,
                                      expected_bytes[0].out_byte,
                                      expected_bytes[0].last_byte));
            end
            void'(expected_bytes.pop_front());
         end
      end
   end

   initial begin : stall_driver
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 32)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      req_payload_type cmd;
      int unsigned     pick;

      add_row(screen_cmd(MODE_CLEAR, 8'h00, 7'd0, 5'd0, 7'd0), 1'b1, 4,
              {BYTE_ESC, BYTE_H, BYTE_ESC, BYTE_J});
      add_row(screen_cmd(MODE_ERASE, 8'h00, 7'd0, 5'd0, 7'd0), 1'b1, 2,
              {BYTE_ESC, BYTE_K, 16'h0000});
      add_row(screen_cmd(MODE_CHAR, 8'h00, 7'd0, 5'd0, 7'd0), 1'b1, 1, {8'h00, 24'h0});
      add_row(screen_cmd(MODE_CHAR, 8'hFF, 7'd0, 5'd0, 7'd0), 1'b1, 1, {8'hFF, 24'h0});
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd1, 7'd2));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd1, 7'd2));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd2, 7'd1));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd3, 7'd1));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd1, 7'd1), 1'b1, 2,
              {BYTE_ESC, BYTE_H, 16'h0000});
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd24, 7'd80), 1'b1, 4,
              {BYTE_ESC, BYTE_F, 8'h23, 8'h79});
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd0, 7'd0), 1'b1, 2,
              {BYTE_ESC, BYTE_H, 16'h0000});
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd31, 7'd127), 1'b1, 4,
              {BYTE_ESC, BYTE_F, 8'h23, 8'h79});
      add_row(screen_cmd(MODE_SPACES, 8'h00, 7'd0, 5'd0, 7'd0), 1'b1, 0, '0);
      add_row(screen_cmd(MODE_SPACES, 8'h00, 7'd64, 5'd0, 7'd0));
      add_row(screen_cmd(MODE_SPACES, 8'h00, 7'd127, 5'd0, 7'd0));
      add_row(screen_cmd(MODE_SPACES, 8'h00, 7'd64, 5'd0, 7'd0));
      add_row(screen_cmd(MODE_CHAR, 8'h41, 7'd0, 5'd0, 7'd0));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd24, 7'd80));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd24, 7'd79));
      add_row(screen_cmd(3'd5, 8'h00, 7'd0, 5'd0, 7'd0), 1'b1, 0, '0);
      add_row(screen_cmd(3'd7, 8'hFF, 7'd127, 5'd31, 7'd127), 1'b1, 0, '0);
      add_row(screen_cmd(MODE_CLEAR, 8'hFF, 7'd127, 5'd31, 7'd127), 1'b1, 4,
              {BYTE_ESC, BYTE_H, BYTE_ESC, BYTE_J});
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd2, 7'd1));
      add_row(screen_cmd(MODE_CHAR, 8'h5A, 7'd0, 5'd0, 7'd0));
      add_row(screen_cmd(MODE_MOVE, 8'h00, 7'd0, 5'd3, 7'd2));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_command(directed_rows[i].cmd, directed_rows[i].typed,
                      directed_rows[i].count, directed_rows[i].seq);
      end

      for (int k = 0; k < RANDOM_COMMANDS; k++) begin
         quiet = (k >= RANDOM_COMMANDS - QUIET_COMMANDS);
         cmd   = 30'($urandom);
         pick  = $urandom_range(0, 99);
         if (pick < 25) begin
            cmd.mode = MODE_CHAR;
         end else if (pick < 40) begin
            cmd.mode = MODE_SPACES;
            if ($urandom_range(0, 7) != 0) cmd.space_count = 7'($urandom_range(0, 6));
         end else if (pick < 75) begin
            cmd.mode = MODE_MOVE;
            case (move_kind_type'($urandom_range(MOVE_STAY, MOVE_ANY)))
               MOVE_STAY: begin
                  cmd.target_row    = cursor_row;
                  cmd.target_column = 7'(cursor_column);
               end
               MOVE_BACK: begin
                  cmd.target_row    = cursor_row;
                  cmd.target_column = 7'(cursor_column - 8'd1);
               end
               MOVE_NEWLINE: begin
                  cmd.target_row    = cursor_row + 5'd1;
                  cmd.target_column = 7'd1;
               end
               MOVE_DOWN: begin
                  cmd.target_row    = cursor_row + 5'd1;
                  cmd.target_column = 7'(cursor_column);
               end
               MOVE_HOME: begin
                  cmd.target_row    = 5'd1;
                  cmd.target_column = 7'd1;
               end
               MOVE_NEAR: begin
                  cmd.target_row    = 5'($urandom_range(1, SCREEN_ROWS));
                  cmd.target_column = 7'($urandom_range(1, SCREEN_COLUMNS));
               end
               default: ;
            endcase
         end else if (pick < 85) begin
            cmd.mode = MODE_ERASE;
         end else if (pick < 92) begin
            cmd.mode = MODE_CLEAR;
         end
         send_command(cmd, 1'b0, 0, '0);
      end

      req_valid <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && expected_bytes.size() != 0; w++) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         note_failure($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("terminal_cursor_escape_encoder_core test passed");
      end else begin
         $display("terminal_cursor_escape_encoder_core test failed");
      end
      $finish;
   end

endmodule

// ===== terminal_cursor_escape_encoder_core.f =====
design/tce_pkg.sv
design/tce_ctrl.sv
design/tce_dp.sv
design/terminal_cursor_escape_encoder_core.sv
tb/tb_terminal_cursor_escape_encoder_core.sv
